@@ rtl/hpt_pkg.sv @@
package hpt_pkg;

  localparam int NumRegs  = 8;
  localparam int CfgIdxW  = 8;
  localparam int MidDepth = 8;
  localparam int MidPtrW  = 3;
  localparam int MidCntW  = 4;
  localparam int OutDepth = 32;
  localparam int OutPtrW  = 5;
  localparam int OutCntW  = 6;
  localparam int QuoW     = 33;
  localparam int DivBits  = 3;
  localparam int DivStages = QuoW / DivBits;

  typedef logic signed [31:0] q_t;

  localparam q_t QMax = 32'sh7fff_ffff;
  localparam q_t QMin = 32'sh8000_0000;

  typedef struct packed {
    q_t px;
    q_t py;
    q_t pz;
  } in_t;

  typedef struct packed {
    q_t   qx;
    q_t   qy;
    q_t   qz;
    logic w_was_zero;
    logic saturated;
  } out_t;

  // Dot products handed from the front to the back.
  typedef struct packed {
    q_t   d0;
    q_t   d1;
    q_t   d2;
    q_t   dw;
    logic sat;
  } mid_t;

  typedef logic [NumRegs-1:0][63:0] mat_t;

  typedef struct packed {
    q_t   v;
    logic sat;
  } qres_t;

  // Identity matrix, Q16.16.
  localparam mat_t MatReset = {
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
  };

  function automatic qres_t clamp64(input logic signed [63:0] v);
    qres_t r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r.v   = QMax;
      r.sat = 1'b1;
    end else if (v < 64'shffff_ffff_8000_0000) begin
      r.v   = QMin;
      r.sat = 1'b1;
    end else begin
      r.v   = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Floor-shift a full Q32.32 product back to Q16.16 and clamp.
  function automatic qres_t qscale(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    return clamp64(s);
  endfunction

  function automatic qres_t qadd(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = $signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b});
    return clamp64(s);
  endfunction

  function automatic q_t elem(input mat_t m, input logic [1:0] row, input logic [1:0] col);
    logic [63:0] r;
    r = m[{row, col[1]}];
    return col[0] ? q_t'(r[63:32]) : q_t'(r[31:0]);
  endfunction

endpackage

@@ rtl/hpt_front.sv @@
module hpt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hpt_pkg::mat_t mat_i,
  input  logic          push_i,
  input  hpt_pkg::in_t  in_i,
  output logic          full_o,
  output logic          mid_push_o,
  output hpt_pkg::mid_t mid_o,
  input  logic          mid_pop_i
);
  import hpt_pkg::*;

  logic               acc;
  logic [3:0]         v_q;
  logic [MidCntW-1:0] cnt_q, cnt_d;

  q_t                 pt [3];
  logic signed [63:0] prod_d [4][3];
  logic signed [63:0] prod_q [4][3];
  q_t                 pc_d [4][3];
  q_t                 pc_q [4][3];
  logic [3:0]         s2sat_d, s2sat_q;
  q_t                 a3_d [4];
  q_t                 a3_q [4];
  q_t                 c3_q [4];
  logic [3:0]         s3sat_d, s3sat_q;
  q_t                 a4_d [4];
  q_t                 a4_q [4];
  logic [3:0]         s4sat_d, s4sat_q;
  q_t                 res [4];
  logic [3:0]         s5sat;

  assign acc    = push_i & ~full_o;
  assign full_o = (cnt_q == MidCntW'(MidDepth));

  assign pt[0] = in_i.px;
  assign pt[1] = in_i.py;
  assign pt[2] = in_i.pz;

  always_comb begin
    qres_t t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = elem(mat_i, 2'(r), 2'(c)) * pt[c];
      end
    end
    for (int r = 0; r < 4; r++) begin
      s2sat_d[r] = 1'b0;
      for (int c = 0; c < 3; c++) begin
        t           = qscale(prod_q[r][c]);
        pc_d[r][c]  = t.v;
        s2sat_d[r]  = s2sat_d[r] | t.sat;
      end
      t          = qadd(pc_q[r][0], pc_q[r][1]);
      a3_d[r]    = t.v;
      s3sat_d[r] = s2sat_q[r] | t.sat;
      t          = qadd(a3_q[r], c3_q[r]);
      a4_d[r]    = t.v;
      s4sat_d[r] = s3sat_q[r] | t.sat;
      t          = qadd(a4_q[r], elem(mat_i, 2'(r), 2'd3));
      res[r]     = t.v;
      s5sat[r]   = s4sat_q[r] | t.sat;
    end
  end

  assign mid_push_o = v_q[3];
  assign mid_o.d0   = res[0];
  assign mid_o.d1   = res[1];
  assign mid_o.d2   = res[2];
  assign mid_o.dw   = res[3];
  assign mid_o.sat  = |s5sat;

  always_comb begin
    cnt_d = cnt_q;
    if (acc && !mid_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!acc && mid_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= '0;
    end else begin
      v_q   <= {v_q[2:0], acc};
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    pc_q    <= pc_d;
    s2sat_q <= s2sat_d;
    a3_q    <= a3_d;
    s3sat_q <= s3sat_d;
    for (int r = 0; r < 4; r++) begin
      c3_q[r] <= pc_q[r][2];
    end
    a4_q    <= a4_d;
    s4sat_q <= s4sat_d;
  end

endmodule

@@ rtl/hpt_queue.sv @@
module hpt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hpt_pkg::mid_t data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output hpt_pkg::mid_t data_o
);
  import hpt_pkg::*;

  mid_t               mem [MidDepth];
  logic [MidPtrW-1:0] wp_q, rp_q;
  logic [MidCntW-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q < MidCntW'(MidDepth))
    else $error("mid queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("mid queue underflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MidCntW'(MidDepth))
    else $error("mid queue count out of range");

endmodule

@@ rtl/hpt_back.sv @@
module hpt_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mid_empty_i,
  input  hpt_pkg::mid_t mid_i,
  output logic          mid_pop_o,
  output logic          empty_o,
  output hpt_pkg::out_t out_o,
  input  logic          pop_i
);
  import hpt_pkg::*;

  typedef struct packed {
    q_t              d0;
    q_t              d1;
    q_t              d2;
    logic [31:0]     dmag;
    logic [31:0]     rem;
    logic [QuoW-1:0] quo;
    logic            neg;
    logic            wz;
    logic            sat;
  } div_t;

  div_t                 dv_q [DivStages+1];
  div_t                 dv_d [DivStages+1];
  logic [DivStages:0]   dvv_q;

  logic                 rv_q;
  q_t                   rd_q [3];
  q_t                   rcp_q;
  logic                 rwz_q, rsat_q;
  q_t                   rcp_d;
  logic                 rsat_d;

  logic                 mv_q;
  logic signed [63:0]   pm_q [3];
  logic                 mwz_q, msat_q;

  out_t                 fin;
  out_t                 omem [OutDepth];
  logic [OutPtrW-1:0]   owp_q, orp_q;
  logic [OutCntW-1:0]   ocnt_q, bcnt_q;
  logic                 opop;

  assign mid_pop_o = ~mid_empty_i & (bcnt_q < OutCntW'(OutDepth));
  assign opop      = pop_i & ~empty_o;

  always_comb begin
    logic [32:0] r33;
    // Load stage: sign and magnitude of w, empty remainder.
    dv_d[0].d0   = mid_i.d0;
    dv_d[0].d1   = mid_i.d1;
    dv_d[0].d2   = mid_i.d2;
    dv_d[0].neg  = mid_i.dw[31];
    dv_d[0].dmag = mid_i.dw[31] ? 32'(~mid_i.dw + 32'd1) : mid_i.dw;
    dv_d[0].rem  = '0;
    dv_d[0].quo  = '0;
    dv_d[0].wz   = (mid_i.dw == '0);
    dv_d[0].sat  = mid_i.sat;
    // Restoring division of 2^32 by |w|, three quotient bits per stage.
    for (int k = 0; k < DivStages; k++) begin
      dv_d[k+1] = dv_q[k];
      for (int j = 0; j < DivBits; j++) begin
        r33 = {dv_d[k+1].rem, ((k == 0) && (j == 0))};
        if (r33 >= {1'b0, dv_d[k+1].dmag}) begin
          r33 = r33 - {1'b0, dv_d[k+1].dmag};
          dv_d[k+1].quo[QuoW-1-DivBits*k-j] = 1'b1;
        end
        dv_d[k+1].rem = r33[31:0];
      end
    end
  end

  // Apply sign and clamp the reciprocal.
  always_comb begin
    div_t s;
    logic rs;
    s  = dv_q[DivStages];
    rs = 1'b0;
    if (!s.neg) begin
      if (s.quo > 33'h0_7fff_ffff) begin
        rcp_d = QMax;
        rs    = 1'b1;
      end else begin
        rcp_d = s.quo[31:0];
      end
    end else begin
      if (s.quo > 33'h0_8000_0000) begin
        rcp_d = QMin;
        rs    = 1'b1;
      end else begin
        rcp_d = 32'(~s.quo[31:0] + 32'd1);
      end
    end
    rsat_d = s.sat | (rs & ~s.wz);
  end

  always_comb begin
    qres_t t [3];
    for (int i = 0; i < 3; i++) begin
      t[i] = qscale(pm_q[i]);
    end
    fin.qx         = mwz_q ? '0 : t[0].v;
    fin.qy         = mwz_q ? '0 : t[1].v;
    fin.qz         = mwz_q ? '0 : t[2].v;
    fin.w_was_zero = mwz_q;
    fin.saturated  = msat_q | (~mwz_q & (t[0].sat | t[1].sat | t[2].sat));
  end

  assign empty_o = (ocnt_q == '0);
  assign out_o   = omem[orp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q  <= '0;
      rv_q   <= 1'b0;
      mv_q   <= 1'b0;
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
      bcnt_q <= '0;
    end else begin
      dvv_q <= {dvv_q[DivStages-1:0], mid_pop_o};
      rv_q  <= dvv_q[DivStages];
      mv_q  <= rv_q;
      if (mv_q) begin
        owp_q <= owp_q + 1'b1;
      end
      if (opop) begin
        orp_q <= orp_q + 1'b1;
      end
      if (mv_q && !opop) begin
        ocnt_q <= ocnt_q + 1'b1;
      end else if (!mv_q && opop) begin
        ocnt_q <= ocnt_q - 1'b1;
      end
      if (mid_pop_o && !opop) begin
        bcnt_q <= bcnt_q + 1'b1;
      end else if (!mid_pop_o && opop) begin
        bcnt_q <= bcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q     <= dv_d;
    rd_q[0]  <= dv_q[DivStages].d0;
    rd_q[1]  <= dv_q[DivStages].d1;
    rd_q[2]  <= dv_q[DivStages].d2;
    rcp_q    <= rcp_d;
    rwz_q    <= dv_q[DivStages].wz;
    rsat_q   <= rsat_d;
    for (int i = 0; i < 3; i++) begin
      pm_q[i] <= rd_q[i] * rcp_q;
    end
    mwz_q    <= rwz_q;
    msat_q   <= rsat_q;
    if (mv_q) begin
      omem[owp_q] <= fin;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= OutCntW'(OutDepth))
    else $error("back credit count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= bcnt_q)
    else $error("result queue holds more than its credits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && out_o.w_was_zero |-> out_o.qx == '0 && out_o.qy == '0 && out_o.qz == '0)
    else $error("zero w result carries nonzero coordinates");

endmodule

@@ rtl/homogeneous_point_transform_top.sv @@
// Homogeneous point transform: each transaction on the input queue carries one
// point (px, py, pz, Q16.16); the block multiplies (x, y, z, 1) by a 4x4
// row-major matrix and divides x, y, z by the resulting w.
// Input side: push_i / full_o, a transaction is taken when push_i is high and
// full_o is low. Result side: empty_o / pop_i, the oldest result sits on out_o
// while empty_o is low and leaves when pop_i is high.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// cfg_ready_o is always high, indexes 0..7 pick a matrix register, others are
// dropped. Write only while no points are in flight.
// Path from accept to result: the product, scale, first-sum and second-sum
// registers of the dot products into the hand-off queue, a pop into the
// divider load stage, eleven radix-8 stages of the 2^32 / w divider, then
// sign/clamp, the coordinate multiply and the final scale into the result queue.
// Throughput: one point per cycle unless stalled; every stage is a plain pipeline.
// Stalls: the front holds credits for its 8-entry hand-off queue and the back
// for its 32-entry result queue, so a stalled receiver first fills the result
// queue, then the hand-off queue, then raises full_o.
// Reset: the matrix returns to identity and all queues empty; no clearing pass.
module homogeneous_point_transform_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  hpt_pkg::in_t                    in_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output hpt_pkg::out_t                   out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpt_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [63:0]                     cfg_data_i
);
  import hpt_pkg::*;

  mat_t mat_q;
  logic mid_push, mid_pop, mid_empty;
  mid_t mid_wr, mid_rd;

  // Configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  // Matrix registers; drop writes beyond the register list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MatReset;
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      mat_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Front: four dot products, clamped at every product and sum.
  hpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mat_i      (mat_q),
    .push_i     (push_i),
    .in_i       (in_i),
    .full_o     (full_o),
    .mid_push_o (mid_push),
    .mid_o      (mid_wr),
    .mid_pop_i  (mid_pop)
  );

  // Hand-off queue between front and back.
  hpt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wr),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .data_o  (mid_rd)
  );

  // Back: reciprocal of w, scaling and the result queue.
  hpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_i       (mid_rd),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty_o),
    .out_o       (out_o),
    .pop_i       (pop_i)
  );

endmodule

@@ tb/sv/tb_homogeneous_point_transform_top.sv @@
`timescale 1ns / 100ps

module tb_homogeneous_point_transform_top;
  import hpt_pkg::*;

  localparam int WatchLimit = 4000;

  // Register indexes, in the order of the matrix register map.
  typedef enum logic [CfgIdxW-1:0] {
    REG_R0_C01 = 8'd0, REG_R0_C23 = 8'd1, REG_R1_C01 = 8'd2, REG_R1_C23 = 8'd3,
    REG_R2_C01 = 8'd4, REG_R2_C23 = 8'd5, REG_R3_C01 = 8'd6, REG_R3_C23 = 8'd7,
    REG_BOGUS  = 8'd200
  } reg_idx_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic full_o;
  in_t in_i = '0;
  logic empty_o;
  logic pop_i = 1'b0;
  out_t out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  homogeneous_point_transform_top u_top (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the matrix, used by the predictor.
  logic [63:0] shadow_mat [NumRegs];
  in_t  point_q [$];
  out_t transformed_q [$];
  int   mismatches = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   recv_hold = 1'b0;
  int   idle_cycles = 0;

  // Clamp a 64-bit value to Q16.16 range, noting saturation.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v,
                                              inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               inout bit sat);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> 16, sat);
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               inout bit sat);
    return sat32(64'(a) + 64'(b), sat);
  endfunction

  function automatic logic signed [31:0] mat_at(input int row, input int col);
    logic [63:0] r;
    r = shadow_mat[row * 2 + col / 2];
    return (col % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic out_t transform_point(input in_t p);
    out_t o;
    bit sat;
    logic signed [31:0] d [4];
    logic signed [31:0] recip;
    logic signed [63:0] quo;
    sat = 1'b0;
    for (int r = 0; r < 4; r++) begin
      d[r] = fx_mul(mat_at(r, 0), p.px, sat);
      d[r] = fx_add(d[r], fx_mul(mat_at(r, 1), p.py, sat), sat);
      d[r] = fx_add(d[r], fx_mul(mat_at(r, 2), p.pz, sat), sat);
      d[r] = fx_add(d[r], mat_at(r, 3), sat);
    end
    o = '0;
    if (d[3] == 0) begin
      o.w_was_zero = 1'b1;
    end else begin
      quo   = 64'sh1_0000_0000 / 64'(d[3]);
      recip = sat32(quo, sat);
      o.qx  = fx_mul(d[0], recip, sat);
      o.qy  = fx_mul(d[1], recip, sat);
      o.qz  = fx_mul(d[2], recip, sat);
    end
    o.saturated = sat;
    return o;
  endfunction

  // Predict each input transaction at the edge that accepts it.
  always @(posedge clk_i) begin
    if (push_i && !full_o) begin
      transformed_q.push_back(transform_point(in_i));
      void'(point_q.pop_front());
    end
  end

  // Driver: offer pending points.
  always @(negedge clk_i) begin
    if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      push_i <= 1'b1;
      in_i   <= point_q[0];
    end else begin
      push_i <= 1'b0;
    end
  end

  // Receiver: pop at random unless held off.
  always @(negedge clk_i) begin
    pop_i <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    out_t exp_o;
    if (rst_ni) begin
      if ((push_i && !full_o) || (pop_i && !empty_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (pop_i && !empty_o) begin
        if (transformed_q.size() == 0) begin
          $error("unexpected result qx=%h", out_o.qx);
          mismatches++;
        end else begin
          exp_o = transformed_q.pop_front();
          if (out_o.qx !== exp_o.qx) begin
            $error("qx exp %h got %h", exp_o.qx, out_o.qx);
            mismatches++;
          end
          if (out_o.qy !== exp_o.qy) begin
            $error("qy exp %h got %h", exp_o.qy, out_o.qy);
            mismatches++;
          end
          if (out_o.qz !== exp_o.qz) begin
            $error("qz exp %h got %h", exp_o.qz, out_o.qz);
            mismatches++;
          end
          if (out_o.w_was_zero !== exp_o.w_was_zero) begin
            $error("w_was_zero exp %b got %b", exp_o.w_was_zero, out_o.w_was_zero);
            mismatches++;
          end
          if (out_o.saturated !== exp_o.saturated) begin
            $error("saturated exp %b got %b", exp_o.saturated, out_o.saturated);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: stop if nothing moves for too long.
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return 32'h8000_0000 | $urandom_range(3);
      1: return 32'h7fff_fffc | $urandom_range(3);
      2: return $urandom_range(4) - 2;
      3: return $urandom;
      default: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic in_t rand_point();
    in_t p;
    p.px = rand_q();
    p.py = rand_q();
    p.pz = rand_q();
    return p;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < NumRegs) shadow_mat[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every prediction is matched, then let the pipe drain.
  task automatic drain();
    while (point_q.size() > 0 || transformed_q.size() > 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic load_matrix(input int kind);
    for (int i = 0; i < NumRegs; i++) begin
      logic [63:0] v;
      case (kind)
        0: v = MatReset[i];
        1: v = {$urandom_range(32'h0003_0000) - 32'h0001_8000,
                $urandom_range(32'h0003_0000) - 32'h0001_8000};
        2: v = {32'h7fff_ffff, 32'h8000_0000};
        default: v = {$urandom, $urandom};
      endcase
      // Keep w close to one so most results are finite.
      if (kind == 1 && i == REG_R3_C23) v = {32'h0001_0000, 32'h0000_0100};
      write_reg(reg_idx_e'(i), v);
    end
  endtask

  initial begin
    in_t p;
    for (int i = 0; i < NumRegs; i++) shadow_mat[i] = MatReset[i];
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: identity, field extremes, zero w, tiny w.
    p = '{32'h7fff_ffff, 32'h8000_0000, 32'h0}; point_q.push_back(p);
    p = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff}; point_q.push_back(p);
    p = '{32'h0001_0000, 32'h0002_8000, 32'hfffe_0000}; point_q.push_back(p);
    drain();
    // w row = z only: zero, +1 and -1 raw w.
    write_reg(REG_R3_C23, 64'h0);
    write_reg(REG_R3_C01, 64'h0);
    write_reg(REG_R3_C23, 64'h0000_0000_0001_0000);
    write_reg(REG_BOGUS, 64'hdead_beef_dead_beef);
    p = '{32'h0003_0000, 32'h0001_0000, 32'h0}; point_q.push_back(p);
    p = '{32'h0003_0000, 32'h0001_0000, 32'h1}; point_q.push_back(p);
    p = '{32'h0003_0000, 32'h0001_0000, 32'hffff_ffff}; point_q.push_back(p);
    p = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h0002_0000}; point_q.push_back(p);
    p = '{32'h8000_0000, 32'h0, 32'h8000_0000}; point_q.push_back(p);
    drain();
    load_matrix(2);
    for (int i = 0; i < 6; i++) point_q.push_back(rand_point());
    drain();

    // Random phases with different idle mixes and matrices.
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph % 3 == 0) ? 23 : (ph % 3 == 1) ? 76 : 0;
      recv_idle_pct = (ph % 3 == 0) ? 76 : (ph % 3 == 1) ? 23 : 0;
      load_matrix(ph == 5 ? 0 : (ph % 2 ? 3 : 1));
      for (int i = 0; i < 240; i++) point_q.push_back(rand_point());
      if (ph == 2) begin
        // Hold off the receiver so the queues fill and full_o rises.
        recv_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        recv_hold = 1'b0;
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hpt_pkg.sv
rtl/hpt_front.sv
rtl/hpt_queue.sv
rtl/hpt_back.sv
rtl/homogeneous_point_transform_top.sv
tb/sv/tb_homogeneous_point_transform_top.sv
